// ===== design/cfbr_pkg.sv =====
package cfbr_pkg;

    // Block dimensions.
    localparam int LINES       = 8;
    localparam int LINE_BITS   = 3;
    localparam int LINE_DEPTH  = 4096;
    localparam int DEPTH_BITS  = 12;
    localparam int ADDR_BITS   = LINE_BITS + DEPTH_BITS;
    localparam int STORE_DEPTH = LINES * LINE_DEPTH;
    localparam int MAX_DELAY   = 2048;
    localparam int SAMPLE_BITS = 24;
    localparam int SUM_BITS    = SAMPLE_BITS + LINE_BITS;
    localparam int CNT_BITS    = 5;
    localparam int WIDE_BITS   = 48;

    // Q1.16 coefficients.
    localparam logic [16:0] Q_ONE       = 17'd65536;
    localparam logic [16:0] MIX_RESET   = 17'd19661;
    localparam logic signed [17:0] LP_NEW = 18'sd6554;
    localparam logic signed [17:0] LP_OLD = 18'sd58982;
    localparam logic signed [17:0] SMOOTH_STEP = 18'sd328;

    // Register map, one 64-bit slot per register.
    typedef enum logic [2:0] {
        REG_SIZE      = 3'd0,
        REG_DENSITY   = 3'd1,
        REG_MIX       = 3'd2,
        REG_LINES     = 3'd3,
        REG_ENABLED   = 3'd4,
        REG_DELAYS_LO = 3'd5,
        REG_DELAYS_HI = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
        logic                          block_start;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } out_item_t;

    // Configuration as seen by the processing logic, already capped.
    typedef struct packed {
        logic [6:0]                          extra;
        logic [16:0]                         atten;
        logic [16:0]                         mix_cap;
        logic [3:0]                          lines;
        logic                                bypass;
        logic [LINES-1:0][DEPTH_BITS-1:0]    base;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SMOOTH,
        ST_READ,
        ST_FILT,
        ST_FEED,
        ST_GAIN,
        ST_WRITE,
        ST_DIV,
        ST_MIX_L,
        ST_MIX_R,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load_in;
        logic smooth;
        logic filt;
        logic feed;
        logic gain;
        logic write;
        logic div_start;
        logic div_step;
        logic mix_l;
        logic mix_r;
        logic load_out;
        logic clear_step;
        logic clear_ack;
    } cmd_t;

    typedef struct packed {
        logic line_last;
        logic div_done;
        logic clear_last;
        logic out_free;
    } status_t;

    // Round a Q16 product to nearest, ties toward plus infinity.
    function automatic logic signed [WIDE_BITS-1:0] rnd16(input logic signed [WIDE_BITS-1:0] x);
        logic signed [WIDE_BITS-1:0] t;
        t = x + 48'sd32768;
        return t >>> 16;
    endfunction

    // Saturate to the sample width.
    function automatic logic signed [SAMPLE_BITS-1:0] sat_s(input logic signed [WIDE_BITS-1:0] x);
        logic signed [WIDE_BITS-1:0] hi;
        logic signed [WIDE_BITS-1:0] lo;
        hi = WIDE_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        lo = -hi - 48'sd1;
        if (x > hi)
            return hi[SAMPLE_BITS-1:0];
        if (x < lo)
            return lo[SAMPLE_BITS-1:0];
        return x[SAMPLE_BITS-1:0];
    endfunction

endpackage

// ===== design/cfbr_ram.sv =====
module cfbr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/cfbr_ctrl.sv =====
module cfbr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             block_start,
    input  logic             bypass,
    input  logic             clear_req,
    input  cfbr_pkg::status_t status,
    output cfbr_pkg::cmd_t   cmd
);

    import cfbr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (clear_req)
                    state_next = ST_CLEAR;
                else if (in_valid)
                begin
                    if (bypass)
                        state_next = ST_OUT;
                    else if (block_start)
                        state_next = ST_SMOOTH;
                    else
                        state_next = ST_READ;
                end
            end
            ST_CLEAR:
            begin
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_SMOOTH: state_next = ST_READ;
            ST_READ:   state_next = ST_FILT;
            ST_FILT:   state_next = ST_FEED;
            ST_FEED:   state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_WRITE;
            ST_WRITE:  state_next = status.line_last ? ST_DIV : ST_READ;
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_MIX_L;
            end
            ST_MIX_L:  state_next = ST_MIX_R;
            ST_MIX_R:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = !clear_req;
                cmd.load_in   = in_valid && !clear_req;
                cmd.clear_ack = clear_req;
            end
            ST_CLEAR:  cmd.clear_step = 1'b1;
            ST_SMOOTH: cmd.smooth = 1'b1;
            ST_READ:   cmd = '0;
            ST_FILT:   cmd.filt = 1'b1;
            ST_FEED:   cmd.feed = 1'b1;
            ST_GAIN:   cmd.gain = 1'b1;
            ST_WRITE:
            begin
                cmd.write     = 1'b1;
                cmd.div_start = status.line_last;
            end
            ST_DIV:    cmd.div_step = 1'b1;
            ST_MIX_L:  cmd.mix_l = 1'b1;
            ST_MIX_R:  cmd.mix_r = 1'b1;
            ST_OUT:    cmd.load_out = status.out_free;
            default:   cmd = '0;
        endcase
    end

    // A new transaction is never taken while a clearing pass is owed.
    a_no_accept_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !clear_req)
        else $error("input accepted while a clear is pending");

    // The clearing pass runs to its last entry.
    a_clear_runs: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && !status.clear_last) |=> state_reg == ST_CLEAR)
        else $error("clearing pass left early");

    // A result is loaded only into a free output slot.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> status.out_free)
        else $error("output register overwritten");

endmodule

// ===== design/cfbr_datapath.sv =====
module cfbr_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cfbr_pkg::cfg_t                    cfg,
    input  cfbr_pkg::in_item_t                in_data,
    input  cfbr_pkg::cmd_t                    cmd,
    output cfbr_pkg::status_t                 status,
    output logic                              out_valid,
    input  logic                              out_ready,
    output cfbr_pkg::out_item_t               out_data,
    output logic                              ram_we,
    output logic [cfbr_pkg::ADDR_BITS-1:0]    ram_waddr,
    output logic [cfbr_pkg::SAMPLE_BITS-1:0]  ram_wdata,
    output logic [cfbr_pkg::ADDR_BITS-1:0]    ram_raddr,
    input  logic [cfbr_pkg::SAMPLE_BITS-1:0]  ram_rdata
);

    import cfbr_pkg::*;

    in_item_t                      in_reg;
    logic                          bypass_reg;
    logic [16:0]                   sm_reg;
    logic [LINE_BITS-1:0]          line_reg;
    logic [DEPTH_BITS-1:0]         wp_reg [LINES];
    logic signed [SAMPLE_BITS-1:0] lp_reg [LINES];
    logic signed [WIDE_BITS-1:0]   prod_reg;
    logic signed [SAMPLE_BITS-1:0] f_reg;
    logic signed [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]           quo_reg;
    logic [4:0]                    rem_reg;
    logic                          neg_reg;
    logic [CNT_BITS-1:0]           cnt_reg;
    logic signed [WIDE_BITS-1:0]   acc_reg;
    logic signed [SAMPLE_BITS-1:0] resl_reg;
    logic [ADDR_BITS-1:0]          clr_reg;
    logic                          out_valid_reg;
    out_item_t                     out_reg;

    logic [DEPTH_BITS-1:0]         wp_cur;
    logic signed [SAMPLE_BITS-1:0] lp_cur;
    logic [DEPTH_BITS:0]           dsum;
    logic [DEPTH_BITS-1:0]         dly;
    logic signed [SAMPLE_BITS:0]   mono;
    logic signed [SUM_BITS-1:0]    sum_next;
    logic [4:0]                    den;
    logic [5:0]                    trial;
    logic                          qbit;
    logic signed [SUM_BITS:0]      q_signed;
    logic signed [SAMPLE_BITS-1:0] wet;
    logic signed [17:0]            m_s;
    logic signed [17:0]            dry_s;
    logic signed [17:0]            atten_s;
    logic signed [18:0]            diff;
    logic signed [WIDE_BITS-1:0]   step;
    logic signed [WIDE_BITS-1:0]   sm_new;
    logic signed [SAMPLE_BITS-1:0] left_s;
    logic signed [SAMPLE_BITS-1:0] right_s;
    logic signed [SAMPLE_BITS-1:0] fb;
    logic signed [SAMPLE_BITS-1:0] f_new;
    logic signed [SAMPLE_BITS-1:0] dly_s;

    assign wp_cur  = wp_reg[line_reg];
    assign lp_cur  = lp_reg[line_reg];
    assign left_s  = in_reg.left_in;
    assign right_s = in_reg.right_in;
    assign dly_s   = signed'(ram_rdata);

    // Read tap of the current line.
    assign dsum = {1'b0, cfg.base[line_reg]} + (DEPTH_BITS + 1)'(cfg.extra);
    assign dly  = (dsum > (DEPTH_BITS + 1)'(MAX_DELAY)) ? DEPTH_BITS'(MAX_DELAY)
                                                        : dsum[DEPTH_BITS-1:0];
    assign mono = ((SAMPLE_BITS + 1)'(left_s) + (SAMPLE_BITS + 1)'(right_s)) >>> 1;

    // Memory ports: clearing pass or feedback write.
    assign ram_raddr = {line_reg, wp_cur - dly};
    assign ram_we    = cmd.clear_step || cmd.write;
    assign ram_waddr = cmd.clear_step ? clr_reg : {line_reg, wp_cur};
    assign fb        = sat_s(WIDE_BITS'(mono) + rnd16(prod_reg));
    assign ram_wdata = cmd.clear_step ? '0 : fb;
    assign f_new     = sat_s(rnd16(prod_reg));

    assign sum_next = sum_reg + SUM_BITS'(f_reg);
    assign atten_s  = signed'({1'b0, cfg.atten});
    assign m_s      = signed'({1'b0, sm_reg});
    assign dry_s    = signed'({1'b0, Q_ONE - sm_reg});

    // One restoring division step per cycle.
    assign den   = 5'(cfg.lines) + 5'd1;
    assign trial = {rem_reg, quo_reg[SUM_BITS-1]};
    assign qbit  = trial >= 6'(den);
    assign q_signed = neg_reg ? -signed'({1'b0, quo_reg}) : signed'({1'b0, quo_reg});
    assign wet   = sat_s(WIDE_BITS'(q_signed));

    // Mix smoothing step.
    assign diff   = signed'({2'b00, cfg.mix_cap}) - signed'({2'b00, sm_reg});
    assign step   = rnd16(WIDE_BITS'(diff * SMOOTH_STEP));
    assign sm_new = WIDE_BITS'(signed'({1'b0, sm_reg})) + step;

    assign status.line_last  = ({1'b0, line_reg} == cfg.lines - 4'd1);
    assign status.div_done   = (cnt_reg == CNT_BITS'(SUM_BITS - 1));
    assign status.clear_last = &clr_reg;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_reg        <= MIX_RESET;
            line_reg      <= '0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < LINES; k++)
            begin
                wp_reg[k] <= '0;
                lp_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.load_in)
                line_reg <= '0;
            if (cmd.smooth)
            begin
                if (sm_new < 0)
                    sm_reg <= '0;
                else if (sm_new > WIDE_BITS'(Q_ONE))
                    sm_reg <= Q_ONE;
                else
                    sm_reg <= sm_new[16:0];
            end
            if (cmd.feed)
                lp_reg[line_reg] <= f_new;
            if (cmd.write)
            begin
                wp_reg[line_reg] <= wp_cur + 1'b1;
                line_reg         <= line_reg + 1'b1;
            end
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
                for (int k = 0; k < LINES; k++)
                begin
                    lp_reg[k] <= '0;
                end
            end
            if (cmd.div_start)
                cnt_reg <= '0;
            else if (cmd.div_step)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_reg     <= in_data;
            bypass_reg <= cfg.bypass;
            sum_reg    <= '0;
        end
        if (cmd.filt)
            prod_reg <= WIDE_BITS'(dly_s * LP_NEW) + WIDE_BITS'(lp_cur * LP_OLD);
        if (cmd.feed)
            f_reg <= f_new;
        if (cmd.gain)
            prod_reg <= WIDE_BITS'(f_reg * atten_s);
        if (cmd.write)
            sum_reg <= sum_next;
        if (cmd.div_start)
        begin
            neg_reg <= sum_next < 0;
            quo_reg <= (sum_next < 0) ? SUM_BITS'(-sum_next) : SUM_BITS'(sum_next);
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= qbit ? 5'(trial - 6'(den)) : trial[4:0];
            quo_reg <= {quo_reg[SUM_BITS-2:0], qbit};
        end
        if (cmd.mix_l)
            acc_reg <= WIDE_BITS'(left_s * dry_s) + WIDE_BITS'(wet * m_s);
        if (cmd.mix_r)
        begin
            resl_reg <= sat_s(rnd16(acc_reg));
            acc_reg  <= WIDE_BITS'(right_s * dry_s) + WIDE_BITS'(wet * m_s);
        end
        if (cmd.load_out)
        begin
            if (bypass_reg)
            begin
                out_reg.left_out  <= left_s;
                out_reg.right_out <= right_s;
            end
            else
            begin
                out_reg.left_out  <= resl_reg;
                out_reg.right_out <= sat_s(rnd16(acc_reg));
            end
        end
    end

endmodule

// ===== design/comb_filter_bank_reverb.sv =====
// Stereo comb-filter reverb. Each accepted transaction carries one Q1.23 stereo
// frame and produces one output frame. When block_start is set, a mix smoothing
// step runs first. The active lines are then run one after the other through the
// single read and write port of the shared delay memory, each line through the
// read, filter, feedback, gain and write states, and the wet sum is normalized by
// a one-bit-per-cycle divider. Bypassed frames go straight to the output.
// A result waiting in the output register stalls the next frame only when that
// frame is ready to be loaded. After reset, and after every write of 0 to the
// enable register, a clearing pass zeroes the delay memory one entry per cycle,
// during which no input is accepted; register writes are taken at all times.
// Registers sit at byte addresses 8*i with 64-bit data.
module comb_filter_bank_reverb (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [5:0]            paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cfbr_pkg::in_item_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cfbr_pkg::out_item_t   out_data
);

    import cfbr_pkg::*;

    logic [6:0]  size_reg;
    logic [16:0] density_reg;
    logic [16:0] mix_reg;
    logic [3:0]  lines_reg;
    logic        enabled_reg;
    logic [47:0] delays_lo_reg;
    logic [47:0] delays_hi_reg;
    logic        clear_req_reg;

    logic                   wr;
    reg_idx_t               idx;
    cfg_t                   cfg;
    cmd_t                   cmd;
    status_t                status;
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_waddr;
    logic [ADDR_BITS-1:0]   ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[5:3]);

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= 7'd50;
            density_reg   <= 17'd32768;
            mix_reg       <= MIX_RESET;
            lines_reg     <= 4'd8;
            enabled_reg   <= 1'b1;
            delays_lo_reg <= '0;
            delays_hi_reg <= '0;
            clear_req_reg <= 1'b1;
        end
        else
        begin
            if (cmd.clear_ack)
                clear_req_reg <= 1'b0;
            if (wr)
            begin
                case (idx)
                    REG_SIZE:      size_reg <= pwdata[6:0];
                    REG_DENSITY:   density_reg <= pwdata[16:0];
                    REG_MIX:       mix_reg <= pwdata[16:0];
                    REG_LINES:     lines_reg <= pwdata[3:0];
                    REG_ENABLED:
                    begin
                        enabled_reg <= pwdata[0];
                        if (!pwdata[0])
                            clear_req_reg <= 1'b1;
                    end
                    REG_DELAYS_LO: delays_lo_reg <= pwdata[47:0];
                    REG_DELAYS_HI: delays_hi_reg <= pwdata[47:0];
                    default:       ;
                endcase
            end
        end
    end

    // Register reads.
    always_comb
    begin
        case (idx)
            REG_SIZE:      prdata = 64'(size_reg);
            REG_DENSITY:   prdata = 64'(density_reg);
            REG_MIX:       prdata = 64'(mix_reg);
            REG_LINES:     prdata = 64'(lines_reg);
            REG_ENABLED:   prdata = 64'(enabled_reg);
            REG_DELAYS_LO: prdata = 64'(delays_lo_reg);
            REG_DELAYS_HI: prdata = 64'(delays_hi_reg);
            default:       prdata = '0;
        endcase
    end

    // Capped values used by the processing logic.
    always_comb
    begin
        cfg.extra   = (size_reg > 7'd100) ? 7'd100 : size_reg;
        cfg.atten   = Q_ONE - (((density_reg > Q_ONE) ? Q_ONE : density_reg) >> 1);
        cfg.mix_cap = (mix_reg > Q_ONE) ? Q_ONE : mix_reg;
        cfg.lines   = (lines_reg > 4'(LINES)) ? 4'(LINES) : lines_reg;
        cfg.bypass  = !enabled_reg || (cfg.lines == 4'd0);
        for (int k = 0; k < LINES / 2; k++)
        begin
            cfg.base[k]             = delays_lo_reg[DEPTH_BITS*k +: DEPTH_BITS];
            cfg.base[k + LINES / 2] = delays_hi_reg[DEPTH_BITS*k +: DEPTH_BITS];
        end
    end

    cfbr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .block_start (in_data.block_start),
        .bypass      (cfg.bypass),
        .clear_req   (clear_req_reg),
        .status      (status),
        .cmd         (cmd)
    );

    cfbr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    cfbr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== sim/comb_filter_bank_reverb_tb.sv =====
`timescale 1ns / 1ps

module comb_filter_bank_reverb_tb;

    import cfbr_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  LINE_CNT    = 8;
    localparam int  LINE_LEN    = 4096;
    localparam int  DELAY_CAP   = 2048;
    localparam int  Q16_ONE     = 65536;
    localparam int  LP_NEW_Q    = 6554;
    localparam int  LP_OLD_Q    = 58982;
    localparam int  MIX_STEP_Q  = 328;
    localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] S_MIN = -24'sh800000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;

    // Reverb model state.
    int          echo_mem [LINE_CNT*LINE_LEN];
    int          head_pos [LINE_CNT];
    longint      lp_hist [LINE_CNT];
    longint      mix_now;
    logic [6:0]  m_size;
    logic [16:0] m_density;
    logic [16:0] m_mix;
    logic [3:0]  m_lines;
    logic        m_enabled;
    logic [47:0] m_delays_lo;
    logic [47:0] m_delays_hi;

    out_item_t   pending_frames [$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    bit          sender_idles = 1'b0;
    int          burst_left = 0;

    comb_filter_bank_reverb dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    // Round a Q16 product to nearest with ties upward.
    function automatic longint q16_round(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clamp24(input longint x);
        if (x > longint'(S_MAX))
            return longint'(S_MAX);
        if (x < longint'(S_MIN))
            return longint'(S_MIN);
        return x;
    endfunction

    function automatic void clear_echo();
        for (int i = 0; i < LINE_CNT*LINE_LEN; i++)
            echo_mem[i] = 0;
        for (int k = 0; k < LINE_CNT; k++)
            lp_hist[k] = 0;
    endfunction

    function automatic void model_reset();
        clear_echo();
        for (int k = 0; k < LINE_CNT; k++)
            head_pos[k] = 0;
        mix_now     = 19661;
        m_size      = 7'd50;
        m_density   = 17'd32768;
        m_mix       = 17'd19661;
        m_lines     = 4'd8;
        m_enabled   = 1'b1;
        m_delays_lo = '0;
        m_delays_hi = '0;
    endfunction

    function automatic void model_write(input reg_idx_t idx, input logic [63:0] v);
        case (idx)
            REG_SIZE:      m_size = v[6:0];
            REG_DENSITY:   m_density = v[16:0];
            REG_MIX:       m_mix = v[16:0];
            REG_LINES:     m_lines = v[3:0];
            REG_ENABLED:
            begin
                m_enabled = v[0];
                if (!v[0])
                    clear_echo();
            end
            REG_DELAYS_LO: m_delays_lo = v[47:0];
            REG_DELAYS_HI: m_delays_hi = v[47:0];
            default: ;
        endcase
    endfunction

    // Compute the output frame of one input frame and advance the comb lines.
    function automatic out_item_t reverb_frame(input in_item_t fr);
        longint    l;
        longint    r;
        longint    mono;
        longint    sum;
        longint    f;
        longint    tap;
        longint    atten;
        longint    wet;
        longint    dry;
        longint    diff;
        int        n;
        int        d;
        int        wp;
        int        rp;
        int        extra;
        out_item_t o;
        l = fr.left_in;
        r = fr.right_in;
        n = (m_lines > 8) ? LINE_CNT : int'(m_lines);
        if (!m_enabled || n == 0)
        begin
            o.left_out  = fr.left_in;
            o.right_out = fr.right_in;
            return o;
        end
        // Mix smoothing runs before this frame is mixed.
        if (fr.block_start)
        begin
            diff = ((m_mix > Q16_ONE) ? Q16_ONE : longint'(m_mix)) - mix_now;
            mix_now += q16_round(diff * MIX_STEP_Q);
            if (mix_now < 0)
                mix_now = 0;
            if (mix_now > Q16_ONE)
                mix_now = Q16_ONE;
        end
        atten = Q16_ONE - (((m_density > Q16_ONE) ? Q16_ONE : longint'(m_density)) >> 1);
        extra = (m_size > 100) ? 100 : int'(m_size);
        mono  = (l + r) >>> 1;
        sum   = 0;
        for (int k = 0; k < n; k++)
        begin
            d = (k < 4) ? int'(m_delays_lo[12*k +: 12]) : int'(m_delays_hi[12*(k-4) +: 12]);
            d = d + extra;
            if (d > DELAY_CAP)
                d = DELAY_CAP;
            d = d % LINE_LEN;
            wp = head_pos[k];
            rp = (wp + LINE_LEN - d) % LINE_LEN;
            tap = echo_mem[k*LINE_LEN + rp];
            f = clamp24(q16_round(tap * LP_NEW_Q + lp_hist[k] * LP_OLD_Q));
            lp_hist[k] = f;
            echo_mem[k*LINE_LEN + wp] = int'(clamp24(mono + q16_round(f * atten)));
            sum += f;
            head_pos[k] = (wp + 1) % LINE_LEN;
        end
        wet = clamp24(sum / longint'(n + 1));
        dry = Q16_ONE - mix_now;
        o.left_out  = 24'(clamp24(q16_round(l * dry + wet * mix_now)));
        o.right_out = 24'(clamp24(q16_round(r * dry + wet * mix_now)));
        return o;
    endfunction

    // Run watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: a long hold when requested, otherwise random stalls.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Compare each output transaction with the oldest predicted frame.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_frames.size() == 0)
            begin
                $error("unexpected output transaction left_out=%0d right_out=%0d",
                       out_data.left_out, out_data.right_out);
                mismatch_count++;
            end
            else
            begin
                want = pending_frames.pop_front();
                if (out_data.left_out !== want.left_out)
                begin
                    $error("left_out expected %0d actual %0d", want.left_out, out_data.left_out);
                    mismatch_count++;
                end
                if (out_data.right_out !== want.right_out)
                begin
                    $error("right_out expected %0d actual %0d", want.right_out,
                           out_data.right_out);
                    mismatch_count++;
                end
            end
        end
    end

    // Offer one frame and hold it until the block takes it.
    task automatic send_frame(input logic signed [23:0] l, input logic signed [23:0] r,
                              input logic bs);
        in_item_t fr;
        fr.left_in     = l;
        fr.right_in    = r;
        fr.block_start = bs;
        in_valid <= 1'b1;
        in_data  <= fr;
        do
            @(posedge clk);
        while (!in_ready);
        pending_frames.push_back(reverb_frame(fr));
        // Bursts with random gaps between them.
        if (sender_idles)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Register write through the bus, issued only once the block has drained its pending frames.
    task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 6'(8 * int'(idx));
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_write(idx, v);
    endtask

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return 24'($signed($urandom_range(0, 2000)) - 1000);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_frame(pick_sample(), pick_sample(), ($urandom_range(0, 3) == 0));
    endtask

    function automatic logic [47:0] pick_delays(input bit shortish);
        logic [47:0] v;
        for (int k = 0; k < 4; k++)
            v[12*k +: 12] = shortish ? 12'($urandom_range(0, 40)) : 12'($urandom);
        return v;
    endfunction

    // Extremes of the sample fields with the reset configuration.
    task automatic test_reset_settings();
        send_frame(S_MAX, S_MAX, 1'b1);
        send_frame(S_MIN, S_MIN, 1'b0);
        send_frame(S_MAX, S_MIN, 1'b1);
        send_frame(S_MIN, S_MAX, 1'b0);
        send_frame(24'sd0, 24'sd0, 1'b0);
        send_frame(-24'sd1, -24'sd1, 1'b1);
        send_frame(24'sd1, -24'sd1, 1'b0);
    endtask

    // Zero delay, capping of out-of-range settings, bypass and re-enable.
    task automatic test_special_cases();
        write_reg(REG_SIZE, 64'd0);
        write_reg(REG_DELAYS_LO, 64'd0);
        send_frame(S_MAX, S_MAX, 1'b1);
        send_frame(S_MIN, S_MAX, 1'b0);
        write_reg(REG_SIZE, 64'd127);
        write_reg(REG_DENSITY, 64'h1FFFF);
        write_reg(REG_MIX, 64'h1FFFF);
        write_reg(REG_LINES, 64'd15);
        write_reg(REG_DELAYS_HI, 64'hFFFF_FFFF_FFFF);
        send_frame(S_MAX, S_MAX, 1'b1);
        send_frame(S_MIN, S_MIN, 1'b1);
        write_reg(REG_LINES, 64'd0);
        send_frame(S_MAX, S_MIN, 1'b1);
        send_frame(24'sd5, -24'sd7, 1'b0);
        write_reg(REG_LINES, 64'd8);
        write_reg(REG_ENABLED, 64'd0);
        send_frame(S_MIN, S_MAX, 1'b1);
        send_frame(24'sd3, 24'sd3, 1'b0);
        write_reg(REG_ENABLED, 64'd1);
        send_frame(S_MAX, S_MAX, 1'b1);
        send_frame(S_MIN, S_MIN, 1'b0);
    endtask

    // A sweep over the extremes of the size, density, mix, lines and delay registers.
    task automatic test_config_extremes();
        write_reg(REG_DENSITY, 64'd0);
        write_reg(REG_MIX, 64'd65536);
        write_reg(REG_SIZE, 64'd100);
        write_reg(REG_LINES, 64'd1);
        write_reg(REG_DELAYS_LO, 64'h0000_0000_0005);
        send_random(40);
        write_reg(REG_DENSITY, 64'd65536);
        write_reg(REG_MIX, 64'd0);
        write_reg(REG_SIZE, 64'd0);
        write_reg(REG_LINES, 64'd8);
        write_reg(REG_DELAYS_LO, pick_delays(1'b1));
        write_reg(REG_DELAYS_HI, pick_delays(1'b1));
        send_random(40);
        write_reg(REG_DELAYS_LO, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_DELAYS_HI, 64'd0);
        write_reg(REG_MIX, 64'd40000);
        send_random(30);
    endtask

    // Long receiver hold so the block backs up, then random receiver stalls.
    task automatic test_backpressure();
        drain();
        hold_left = 3000;
        send_random(30);
        drain();
        stall_pct = 30;
        send_random(20);
    endtask

    // Random phases with random settings, short delays mostly for dense feedback.
    task automatic test_random_traffic();
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(REG_SIZE, 64'($urandom_range(0, 127)));
            write_reg(REG_DENSITY, 64'($urandom_range(0, 131071)));
            write_reg(REG_MIX, 64'($urandom_range(0, 131071)));
            write_reg(REG_LINES, 64'($urandom_range(0, 15)));
            write_reg(REG_DELAYS_LO, pick_delays($urandom_range(0, 3) != 0));
            write_reg(REG_DELAYS_HI, pick_delays($urandom_range(0, 3) != 0));
            if (ph == 6)
            begin
                write_reg(REG_ENABLED, 64'd0);
                send_random(10);
                write_reg(REG_ENABLED, 64'd1);
            end
            stall_pct    = (ph % 4 == 0) ? 0 : $urandom_range(10, 60);
            sender_idles = (ph % 4 != 1);
            send_random(50);
        end
    endtask

    initial
    begin
        model_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_settings();
        test_special_cases();
        sender_idles = 1'b1;
        stall_pct = 25;
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        drain();
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
